>>> rtl/mpf_pkg.sv
// ----------------------------------------------------------------------------
// mpf_pkg
// shared widths, request codes and status codes of the multilevel priority fifo
// ----------------------------------------------------------------------------
package mpf_pkg;

    // field widths
    localparam int DATA_W   = 32;
    localparam int LEVEL_W  = 4;
    localparam int STATUS_W = 2;

    // stream word widths, padded to whole bytes
    localparam int S_TDATA_W = ((LEVEL_W + DATA_W + 7) / 8) * 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = ((DATA_W + LEVEL_W + 7) / 8) * 8;
    localparam int M_TUSER_W = STATUS_W;

    // request kinds
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

>>> rtl/mpf_ram.sv
// ----------------------------------------------------------------------------
// mpf_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mpf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 704
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/multilevel_priority_fifo.sv
// ----------------------------------------------------------------------------
// multilevel_priority_fifo
// priority queue of MAX_LEVEL+1 fifo levels sharing one entry ram
// ----------------------------------------------------------------------------
// sequence: a request word is taken in IDLE and its result word is registered in EXEC,
//   where a dequeue uses the registered read of the entry ram; a stalled result output
//   holds EXEC, and no new request is taken until the block is back in IDLE
// reset: pointers and level counts clear at once, no clearing pass; the entry
//   ram is not cleared, an entry is only read after it has been written
// ----------------------------------------------------------------------------
module multilevel_priority_fifo #(
    parameter int MAX_LEVEL   = 10,
    parameter int LEVEL_DEPTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // request side
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [mpf_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // priority_req, data_in, zero pad
    input  logic [mpf_pkg::S_TUSER_W-1:0]  s_axis_tuser,  // req_type
    // result side
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [mpf_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // data_out, served_level, zero pad
    output logic [mpf_pkg::M_TUSER_W-1:0]  m_axis_tuser   // status
);

    import mpf_pkg::*;

    localparam int NUM_LEVELS = MAX_LEVEL + 1;
    localparam int LVL_W      = $clog2(NUM_LEVELS);
    localparam int PTR_W      = $clog2(LEVEL_DEPTH);
    localparam int CNT_W      = $clog2(LEVEL_DEPTH + 1);
    localparam int NUM_WORDS  = NUM_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W     = $clog2(NUM_WORDS);
    localparam int PAD_W      = M_TDATA_W - DATA_W - LEVEL_W;

    typedef enum logic {
        IDLE,
        EXEC
    } state_t;

    state_t state_reg;

    // per-level bookkeeping, cleared by reset
    logic [PTR_W-1:0] rd_ptr_reg [NUM_LEVELS];
    logic [PTR_W-1:0] wr_ptr_reg [NUM_LEVELS];
    logic [CNT_W-1:0] cnt_reg    [NUM_LEVELS];

    // request fields
    logic               in_req;
    logic [LEVEL_W-1:0] in_prio;
    logic [DATA_W-1:0]  in_data;

    assign in_req  = s_axis_tuser[0];
    assign in_prio = s_axis_tdata[LEVEL_W-1:0];
    assign in_data = s_axis_tdata[LEVEL_W +: DATA_W];

    logic s_fire;
    assign s_axis_tready = (state_reg == IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // enqueue level, saturated to the top level
    logic [LVL_W-1:0] enq_lvl;
    assign enq_lvl = (int'(in_prio) > MAX_LEVEL) ? LVL_W'(MAX_LEVEL) : LVL_W'(in_prio);

    // highest non-empty level, last hit in ascending order wins
    logic             deq_found;
    logic [LVL_W-1:0] deq_lvl;

    always_comb
    begin
        deq_found = 1'b0;
        deq_lvl   = '0;
        for (int k = 0; k < NUM_LEVELS; k++)
        begin
            if (cnt_reg[k] != '0)
            begin
                deq_found = 1'b1;
                deq_lvl   = LVL_W'(k);
            end
        end
    end

    // selected level and its pointer
    logic [LVL_W-1:0]  sel_lvl;
    logic [CNT_W-1:0]  sel_cnt;
    logic [PTR_W-1:0]  sel_ptr;
    logic [PTR_W-1:0]  ptr_adv;
    logic              enq_full;
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we;
    logic              ram_re;
    logic [DATA_W-1:0] ram_rdata;

    assign sel_lvl  = (in_req == REQ_DEQ) ? deq_lvl : enq_lvl;
    assign sel_cnt  = cnt_reg[sel_lvl];
    assign sel_ptr  = (in_req == REQ_DEQ) ? rd_ptr_reg[sel_lvl] : wr_ptr_reg[sel_lvl];
    assign ptr_adv  = (sel_ptr == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : sel_ptr + 1'b1;
    assign enq_full = (sel_cnt == CNT_W'(LEVEL_DEPTH));

    // each level owns a contiguous block of LEVEL_DEPTH entries
    assign ram_addr = ADDR_W'(sel_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(sel_ptr);

    // enqueue writes and dequeue reads at the accepting edge
    assign ram_we = s_fire && (in_req == REQ_ENQ) && !enq_full;
    assign ram_re = s_fire && (in_req == REQ_DEQ) && deq_found;

    mpf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_WORDS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (in_data),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // pointer and count update, one level per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_LEVELS; k++)
            begin
                rd_ptr_reg[k] <= '0;
                wr_ptr_reg[k] <= '0;
                cnt_reg[k]    <= '0;
            end
        end
        else if (ram_we)
        begin
            wr_ptr_reg[sel_lvl] <= ptr_adv;
            cnt_reg[sel_lvl]    <= sel_cnt + 1'b1;
        end
        else if (ram_re)
        begin
            rd_ptr_reg[sel_lvl] <= ptr_adv;
            cnt_reg[sel_lvl]    <= sel_cnt - 1'b1;
        end
    end

    // outcome of the request, known at the accepting edge
    status_t          op_status_next;
    logic [LVL_W-1:0] op_level_next;

    always_comb
    begin
        if (in_req == REQ_DEQ)
        begin
            op_status_next = deq_found ? ST_OK : ST_EMPTY;
            op_level_next  = deq_found ? deq_lvl : '0;
        end
        else
        begin
            op_status_next = enq_full ? ST_FULL : ST_OK;
            op_level_next  = enq_lvl;
        end
    end

    status_t            op_status_reg;
    logic [LEVEL_W-1:0] op_level_reg;
    logic               op_read_reg;

    logic               m_valid_reg;
    logic [DATA_W-1:0]  m_data_reg;
    logic [LEVEL_W-1:0] m_level_reg;
    status_t            m_status_reg;

    // control sequence and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            op_status_reg <= ST_OK;
            op_level_reg  <= '0;
            op_read_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
            m_level_reg   <= '0;
            m_status_reg  <= ST_OK;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    if (m_valid_reg && m_axis_tready)
                    begin
                        m_valid_reg <= 1'b0;
                    end
                    if (s_fire)
                    begin
                        op_status_reg <= op_status_next;
                        op_level_reg  <= LEVEL_W'(op_level_next);
                        op_read_reg   <= ram_re;
                        state_reg     <= EXEC;
                    end
                end
                EXEC:
                begin
                    // ram read data holds while the result slot is busy
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_data_reg   <= op_read_reg ? ram_rdata : '0;
                        m_level_reg  <= op_level_reg;
                        m_status_reg <= op_status_reg;
                        state_reg    <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {PAD_W'(0), m_level_reg, m_data_reg};
    assign m_axis_tuser  = m_status_reg;

`ifndef SYNTHESIS
    // the entry ram is never written and read by the same request
    assert property (@(posedge clk) disable iff (!rst_n) !(ram_we && ram_re))
        else $error("entry ram written and read in one cycle");

    // every accepted request moves on to the execute step
    assert property (@(posedge clk) disable iff (!rst_n) s_fire |=> state_reg == EXEC)
        else $error("accepted request did not enter execute");

    // a result word only appears out of the execute step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == EXEC))
        else $error("result word raised outside execute");

    // a refused enqueue leaves the level count at full
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && in_req == REQ_ENQ && enq_full) |=> cnt_reg[$past(sel_lvl)] == CNT_W'(LEVEL_DEPTH))
        else $error("full level count changed on refused enqueue");
`endif

endmodule
